/* sv/pclns_pkg.sv */
// ----------------------------------------------------------------------------
// pclns_pkg
// Shared types, codes and sizes of the periodic cell-list neighbor search.
// ----------------------------------------------------------------------------
package pclns_pkg;

   localparam int NUM_PARTICLES  = 4096;
   localparam int IDX_W          = 12;
   localparam int CNT_W          = 13;
   localparam int LINK_W         = 13;
   localparam int NUM_CELLS      = 4096;
   localparam int CID_W          = 12;
   localparam int CELL_W         = 6;
   localparam int N_W            = 7;
   localparam int MAX_CELLS_SIDE = 64;
   localparam int MAX_NEIGHBORS  = 63;
   localparam int TOT_W          = 6;
   localparam int COORD_W        = 24;
   localparam int SCALE_W        = 32;
   localparam int RSQ_W          = 48;
   localparam int PROD_W         = COORD_W + SCALE_W;

   localparam logic [LINK_W-1:0] EMPTY_LINK = {LINK_W{1'b1}};

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] STAT_VALID = 2'd0;
   localparam logic [1:0] STAT_NONE  = 2'd1;
   localparam logic [1:0] STAT_TRUNC = 2'd2;
   localparam logic [1:0] STAT_BAD   = 2'd3;

   localparam logic [1:0] REG_BOX   = 2'd0;
   localparam logic [1:0] REG_RSQ   = 2'd1;
   localparam logic [1:0] REG_CELLS = 2'd2;
   localparam logic [1:0] REG_SCALE = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [IDX_W-1:0]   query_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] neighbor_index;
      logic [TOT_W-1:0] neighbor_total;
      logic [1:0]       status;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] box_length;
      logic [RSQ_W-1:0]   radius_squared;
      logic [N_W-1:0]     cells_per_side;
      logic [SCALE_W-1:0] cell_scale;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } push_type;

endpackage

/* sv/periodic_cell_list_neighbor_search.sv */
// ----------------------------------------------------------------------------
// periodic_cell_list_neighbor_search
// Fixed-radius 2D neighbor search in a periodic box using a cell list.
// ----------------------------------------------------------------------------
// Results leave one beat per cycle on rsp_strobe and cannot be held off; a
// query's run of matches comes out in consecutive cycles, ascending, with
// last set on the final beat. After reset busy stays high while every cell
// head is swept to empty. Commands go through a two-beat queue to a single
// sequential engine, so busy drops again as soon as the queue has room.
// Engine work per command:
//   clear  the same head sweep, one cell a cycle.
//   load   two remainder steps bin x and y into cells, then the particle is
//          linked in front of its cell's list.
//   query  bin the queried particle, then scan up to nine cells and test each
//          particle in them, with a remainder step for each axis whose raw
//          distance reaches the box length, then report the matches.
// One remainder unit is shared, and each store has a single read port.
// ----------------------------------------------------------------------------
module periodic_cell_list_neighbor_search
   import pclns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   // result channel
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   logic       init_busy, fifo_full, fifo_empty, fifo_pop;
   push_type   push;
   req_type    fifo_head;

   // registers sit on 8-byte strides since the radius needs 48 bits
   always_comb begin
      reg_sel = paddr[4:3];
      wr_en   = psel && penable && pwrite;
      cfg_in  = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_BOX:   cfg_in.box_length     = pwdata[COORD_W-1:0];
            REG_RSQ:   cfg_in.radius_squared = pwdata[RSQ_W-1:0];
            REG_CELLS: cfg_in.cells_per_side = pwdata[N_W-1:0];
            default:   cfg_in.cell_scale     = pwdata[SCALE_W-1:0];
         endcase
      end
      case (reg_sel)
         REG_BOX:   prdata = 64'(cfg_ff.box_length);
         REG_RSQ:   prdata = 64'(cfg_ff.radius_squared);
         REG_CELLS: prdata = 64'(cfg_ff.cells_per_side);
         default:   prdata = 64'(cfg_ff.cell_scale);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_length     <= COORD_W'(24'h80_0000);
         cfg_ff.radius_squared <= RSQ_W'(48'h0001_0000_0000);
         cfg_ff.cells_per_side <= N_W'(MAX_CELLS_SIDE);
         cfg_ff.cell_scale     <= SCALE_W'(32'h0000_8000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;

   // hold the incoming beat and classify it
   pclns_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .init_busy (init_busy),
      .fifo_full (fifo_full),
      .busy      (busy),
      .push      (push)
   );

   // decouple intake from the engine
   pclns_cmd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (fifo_pop),
      .full  (fifo_full),
      .empty (fifo_empty),
      .head  (fifo_head)
   );

   // run clears, loads and queries one at a time
   pclns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .fifo_head  (fifo_head),
      .fifo_pop   (fifo_pop),
      .init_busy  (init_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* sv/pclns_mod.sv */
// ----------------------------------------------------------------------------
// pclns_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pclns_mod
   import pclns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] dividend,
   input  logic [COORD_W-1:0] divisor,
   output logic               done,
   output logic [COORD_W-1:0] remainder
);

   localparam int STEP_W = $clog2(COORD_W);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COORD_W-1:0] dvd_ff, dvd_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W:0]   trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[COORD_W-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = COORD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[COORD_W-1:0];
         end
         dvd_in  = {dvd_ff[COORD_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(COORD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* sv/pclns_back.sv */
// ----------------------------------------------------------------------------
// pclns_back
// Command engine: cell sweep, particle load and binning, query walk over up
// to 3x3 cells, distance test, sorted match row and result emission.
// ----------------------------------------------------------------------------
module pclns_back
   import pclns_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fifo_empty,
   input  req_type fifo_head,
   output logic    fifo_pop,
   output logic    init_busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_SWEEP     = 5'd0;
   localparam logic [ST_W-1:0] S_IDLE      = 5'd1;
   localparam logic [ST_W-1:0] S_LD_MUL    = 5'd2;
   localparam logic [ST_W-1:0] S_BX        = 5'd3;
   localparam logic [ST_W-1:0] S_BY        = 5'd4;
   localparam logic [ST_W-1:0] S_MOD_WAIT  = 5'd5;
   localparam logic [ST_W-1:0] S_LD_CID    = 5'd6;
   localparam logic [ST_W-1:0] S_LD_RD     = 5'd7;
   localparam logic [ST_W-1:0] S_LD_WR     = 5'd8;
   localparam logic [ST_W-1:0] S_Q_CHK     = 5'd9;
   localparam logic [ST_W-1:0] S_Q_MUL     = 5'd10;
   localparam logic [ST_W-1:0] S_CELL_INIT = 5'd11;
   localparam logic [ST_W-1:0] S_CELL      = 5'd12;
   localparam logic [ST_W-1:0] S_CELL_RD   = 5'd13;
   localparam logic [ST_W-1:0] S_HEAD      = 5'd14;
   localparam logic [ST_W-1:0] S_WALK      = 5'd15;
   localparam logic [ST_W-1:0] S_P_DATA    = 5'd16;
   localparam logic [ST_W-1:0] S_P_MX      = 5'd17;
   localparam logic [ST_W-1:0] S_P_MY      = 5'd18;
   localparam logic [ST_W-1:0] S_P_FOLD    = 5'd19;
   localparam logic [ST_W-1:0] S_P_SQ      = 5'd20;
   localparam logic [ST_W-1:0] S_P_CMP     = 5'd21;
   localparam logic [ST_W-1:0] S_EMIT      = 5'd22;

   localparam logic [1:0] DST_CX = 2'd0;
   localparam logic [1:0] DST_CY = 2'd1;
   localparam logic [1:0] DST_DX = 2'd2;
   localparam logic [1:0] DST_DY = 2'd3;

   localparam int SQ_W = 2 * COORD_W;

   // particle and cell stores
   logic [COORD_W-1:0] x_mem    [0:NUM_PARTICLES-1];
   logic [COORD_W-1:0] y_mem    [0:NUM_PARTICLES-1];
   logic [LINK_W-1:0]  link_mem [0:NUM_PARTICLES-1];
   logic [LINK_W-1:0]  head_mem [0:NUM_CELLS-1];

   logic [ST_W-1:0]    state_ff, state_in, ret_ff, ret_in;
   logic               init_ff, init_in;
   req_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CID_W-1:0]   sw_ff, sw_in;
   logic [PROD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [CELL_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [1:0]         a_ff, a_in, b_ff, b_in, dst_ff, dst_in;
   logic [CID_W-1:0]   cid_ff, cid_in;
   logic [LINK_W-1:0]  j_ff, j_in, link_ff, link_in;
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [IDX_W-1:0]   buf_ff [0:MAX_NEIGHBORS-1];
   logic [IDX_W-1:0]   buf_in [0:MAX_NEIGHBORS-1];
   logic [TOT_W-1:0]   mcnt_ff, mcnt_in, tot_ff, tot_in;
   logic               over_ff, over_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COORD_W-1:0] x_rd_ff, y_rd_ff;
   logic [LINK_W-1:0]  link_rd_ff, head_rd_ff;
   logic [IDX_W-1:0]   xy_ra;
   logic               pt_we, head_we;
   logic [CID_W-1:0]   head_wa;
   logic [LINK_W-1:0]  head_wd;

   logic               mod_start, mod_done;
   logic [COORD_W-1:0] mod_dvd, mod_div, mod_rem;

   logic [N_W-1:0]     n;
   logic [1:0]         nx;
   logic [N_W:0]       vx_raw, vy_raw, n2;
   logic [CELL_W-1:0]  vx, vy;
   logic [IDX_W-1:0]   jn;
   logic [SQ_W:0]      dist_sum;
   logic               hit, ins_ok;
   logic [MAX_NEIGHBORS-1:0] gt, gtp;

   pclns_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      // clamp the cell count into one to the grid maximum
      if (cfg.cells_per_side == '0) begin
         n = N_W'(1);
      end else if (cfg.cells_per_side > N_W'(MAX_CELLS_SIDE)) begin
         n = N_W'(MAX_CELLS_SIDE);
      end else begin
         n = cfg.cells_per_side;
      end
      nx = (n < N_W'(3)) ? n[1:0] : 2'd3;
      n2 = {n, 1'b0};
      // wrapped neighbor cell coordinates
      vx_raw = (N_W+1)'(cx_ff) + (N_W+1)'(a_ff) + (N_W+1)'(n) - 1'b1;
      vy_raw = (N_W+1)'(cy_ff) + (N_W+1)'(b_ff) + (N_W+1)'(n) - 1'b1;
      if (vx_raw >= n2) begin
         vx = CELL_W'(vx_raw - n2);
      end else if (vx_raw >= {1'b0, n}) begin
         vx = CELL_W'(vx_raw - {1'b0, n});
      end else begin
         vx = CELL_W'(vx_raw);
      end
      if (vy_raw >= n2) begin
         vy = CELL_W'(vy_raw - n2);
      end else if (vy_raw >= {1'b0, n}) begin
         vy = CELL_W'(vy_raw - {1'b0, n});
      end else begin
         vy = CELL_W'(vy_raw);
      end
   end

   // sorted insert into the match row
   always_comb begin
      jn       = j_ff[IDX_W-1:0];
      dist_sum = {1'b0, sx_ff} + {1'b0, sy_ff};
      hit      = (jn != cmd_ff.query_index) &&
                 (dist_sum <= (SQ_W+1)'(cfg.radius_squared));
      for (int k = 0; k < MAX_NEIGHBORS; k++) begin
         gt[k] = (TOT_W'(k) < mcnt_ff) && (buf_ff[k] > jn);
      end
      gtp    = {gt[MAX_NEIGHBORS-2:0], 1'b0};
      ins_ok = hit && ((mcnt_ff < TOT_W'(MAX_NEIGHBORS)) || gt[MAX_NEIGHBORS-1]);
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      init_in       = init_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      sw_in         = sw_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      dst_in        = dst_ff;
      cid_in        = cid_ff;
      j_in          = j_ff;
      link_in       = link_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      buf_in        = buf_ff;
      mcnt_in       = mcnt_ff;
      tot_in        = tot_ff;
      over_in       = over_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      fifo_pop      = 1'b0;
      mod_start     = 1'b0;
      mod_dvd       = px_ff[PROD_W-1:SCALE_W];
      mod_div       = COORD_W'(n);
      pt_we         = 1'b0;
      head_we       = 1'b0;
      head_wa       = cid_ff;
      head_wd       = cnt_ff;
      xy_ra         = jn;

      case (state_ff)
         S_SWEEP: begin
            head_we = 1'b1;
            head_wa = sw_ff;
            head_wd = EMPTY_LINK;
            sw_in   = sw_ff + 1'b1;
            if (sw_ff == CID_W'(NUM_CELLS - 1)) begin
               init_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               cmd_in   = fifo_head;
               case (fifo_head.kind)
                  KIND_CLEAR: begin
                     cnt_in   = '0;
                     sw_in    = '0;
                     state_in = S_SWEEP;
                  end
                  KIND_LOAD: begin
                     // drop the load when the store is full
                     if (cnt_ff != CNT_W'(NUM_PARTICLES)) begin
                        state_in = S_LD_MUL;
                     end
                  end
                  KIND_QUERY: state_in = S_Q_CHK;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LD_MUL: begin
            px_in    = cmd_ff.pos_x * cfg.cell_scale;
            py_in    = cmd_ff.pos_y * cfg.cell_scale;
            state_in = S_BX;
         end
         S_BX: begin
            mod_start = 1'b1;
            dst_in    = DST_CX;
            ret_in    = S_BY;
            state_in  = S_MOD_WAIT;
         end
         S_BY: begin
            mod_start = 1'b1;
            mod_dvd   = py_ff[PROD_W-1:SCALE_W];
            dst_in    = DST_CY;
            ret_in    = (cmd_ff.kind == KIND_LOAD) ? S_LD_CID : S_CELL_INIT;
            state_in  = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (mod_done) begin
               case (dst_ff)
                  DST_CX:  cx_in = mod_rem[CELL_W-1:0];
                  DST_CY:  cy_in = mod_rem[CELL_W-1:0];
                  DST_DX:  dx_in = mod_rem;
                  default: dy_in = mod_rem;
               endcase
               state_in = ret_ff;
            end
         end
         S_LD_CID: begin
            cid_in   = CID_W'(cy_ff * n + (N_W+CELL_W)'(cx_ff));
            state_in = S_LD_RD;
         end
         S_LD_RD: begin
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            // link the new particle in front of the cell's list
            pt_we    = 1'b1;
            head_we  = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_Q_CHK: begin
            xy_ra = cmd_ff.query_index;
            if ({1'b0, cmd_ff.query_index} >= cnt_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{neighbor_index: '0, neighbor_total: '0,
                                 status: STAT_BAD, last: 1'b1};
               state_in      = S_IDLE;
            end else begin
               state_in = S_Q_MUL;
            end
         end
         S_Q_MUL: begin
            qx_in    = x_rd_ff;
            qy_in    = y_rd_ff;
            px_in    = x_rd_ff * cfg.cell_scale;
            py_in    = y_rd_ff * cfg.cell_scale;
            state_in = S_BX;
         end
         S_CELL_INIT: begin
            a_in     = '0;
            b_in     = '0;
            mcnt_in  = '0;
            over_in  = 1'b0;
            state_in = S_CELL;
         end
         S_CELL: begin
            cid_in   = CID_W'(vy * n + (N_W+CELL_W)'(vx));
            state_in = S_CELL_RD;
         end
         S_CELL_RD: begin
            state_in = S_HEAD;
         end
         S_HEAD: begin
            j_in     = head_rd_ff;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (j_ff >= cnt_ff) begin
               // end of this cell's list: advance to the next distinct cell
               if (b_ff + 1'b1 < nx) begin
                  b_in     = b_ff + 1'b1;
                  state_in = S_CELL;
               end else if (a_ff + 1'b1 < nx) begin
                  a_in     = a_ff + 1'b1;
                  b_in     = '0;
                  state_in = S_CELL;
               end else begin
                  tot_in   = mcnt_ff;
                  state_in = S_EMIT;
               end
            end else begin
               state_in = S_P_DATA;
            end
         end
         S_P_DATA: begin
            dx_in    = (qx_ff > x_rd_ff) ? qx_ff - x_rd_ff : x_rd_ff - qx_ff;
            dy_in    = (qy_ff > y_rd_ff) ? qy_ff - y_rd_ff : y_rd_ff - qy_ff;
            link_in  = link_rd_ff;
            state_in = S_P_MX;
         end
         S_P_MX: begin
            state_in = S_P_MY;
            if ((cfg.box_length != '0) && (dx_ff >= cfg.box_length)) begin
               mod_start = 1'b1;
               mod_dvd   = dx_ff;
               mod_div   = cfg.box_length;
               dst_in    = DST_DX;
               ret_in    = S_P_MY;
               state_in  = S_MOD_WAIT;
            end
         end
         S_P_MY: begin
            state_in = S_P_FOLD;
            if ((cfg.box_length != '0) && (dy_ff >= cfg.box_length)) begin
               mod_start = 1'b1;
               mod_dvd   = dy_ff;
               mod_div   = cfg.box_length;
               dst_in    = DST_DY;
               ret_in    = S_P_FOLD;
               state_in  = S_MOD_WAIT;
            end
         end
         S_P_FOLD: begin
            // take the minimum image
            if (cfg.box_length != '0) begin
               if ({dx_ff, 1'b0} > {1'b0, cfg.box_length}) begin
                  dx_in = cfg.box_length - dx_ff;
               end
               if ({dy_ff, 1'b0} > {1'b0, cfg.box_length}) begin
                  dy_in = cfg.box_length - dy_ff;
               end
            end
            state_in = S_P_SQ;
         end
         S_P_SQ: begin
            sx_in    = dx_ff * dx_ff;
            sy_in    = dy_ff * dy_ff;
            state_in = S_P_CMP;
         end
         S_P_CMP: begin
            if (hit) begin
               if (mcnt_ff < TOT_W'(MAX_NEIGHBORS)) begin
                  mcnt_in = mcnt_ff + 1'b1;
               end else begin
                  over_in = 1'b1;
               end
            end
            if (ins_ok) begin
               if (gt[0] || (mcnt_ff == '0)) begin
                  buf_in[0] = jn;
               end
               for (int k = 1; k < MAX_NEIGHBORS; k++) begin
                  if (gtp[k]) begin
                     buf_in[k] = buf_ff[k-1];
                  end else if (gt[k] || (TOT_W'(k) == mcnt_ff)) begin
                     buf_in[k] = jn;
                  end
               end
            end
            j_in     = link_ff;
            state_in = S_WALK;
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            if (mcnt_ff == '0) begin
               rsp_in   = '{neighbor_index: '0, neighbor_total: '0,
                            status: STAT_NONE, last: 1'b1};
               state_in = S_IDLE;
            end else begin
               rsp_in = '{neighbor_index: buf_ff[0], neighbor_total: tot_ff,
                          status: over_ff ? STAT_TRUNC : STAT_VALID,
                          last: (mcnt_ff == TOT_W'(1))};
               for (int k = 0; k < MAX_NEIGHBORS - 1; k++) begin
                  buf_in[k] = buf_ff[k+1];
               end
               mcnt_in = mcnt_ff - 1'b1;
               if (mcnt_ff == TOT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // store ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (pt_we) begin
         x_mem[cnt_ff[IDX_W-1:0]]    <= cmd_ff.pos_x;
         y_mem[cnt_ff[IDX_W-1:0]]    <= cmd_ff.pos_y;
         link_mem[cnt_ff[IDX_W-1:0]] <= head_rd_ff;
      end
      x_rd_ff    <= x_mem[xy_ra];
      y_rd_ff    <= y_mem[xy_ra];
      link_rd_ff <= link_mem[xy_ra];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem[cid_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         init_ff       <= 1'b1;
         sw_ff         <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         sw_ff         <= sw_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ret_ff  <= ret_in;
      cmd_ff  <= cmd_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dst_ff  <= dst_in;
      cid_ff  <= cid_in;
      j_ff    <= j_in;
      link_ff <= link_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      buf_ff  <= buf_in;
      mcnt_ff <= mcnt_in;
      tot_ff  <= tot_in;
      over_ff <= over_in;
      rsp_ff  <= rsp_in;
   end

   assign init_busy  = init_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* sv/pclns_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pclns_cmd_fifo
// Two-entry command queue between the front and the engine.
// ----------------------------------------------------------------------------
module pclns_cmd_fifo
   import pclns_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output req_type  head
);

   req_type    ent_ff [0:1];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      do_push = push.valid && (cnt_ff != 2'd2);
      do_pop  = pop && (cnt_ff != 2'd0);
      wr_in   = do_push ? ~wr_ff : wr_ff;
      rd_in   = do_pop ? ~rd_ff : rd_ff;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         ent_ff[wr_ff] <= push.item;
      end
   end

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = ent_ff[rd_ff];

endmodule

/* sv/pclns_front.sv */
// ----------------------------------------------------------------------------
// pclns_front
// Command intake: hold one beat, drop unknown kinds, push the rest.
// ----------------------------------------------------------------------------
module pclns_front
   import pclns_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_data,
   input  logic     init_busy,
   input  logic     fifo_full,
   output logic     busy,
   output push_type push
);

   logic    hold_ff, hold_in;
   req_type item_ff, item_in;
   logic    accept, drop, leave;

   always_comb begin
      busy       = init_busy || (hold_ff && fifo_full);
      accept     = start && !busy;
      drop       = (item_ff.kind == KIND_NONE);
      leave      = hold_ff && (drop || !fifo_full);
      push.valid = hold_ff && !drop && !fifo_full;
      push.item  = item_ff;
      hold_in    = accept ? 1'b1 : (leave ? 1'b0 : hold_ff);
      item_in    = accept ? req_data : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      item_ff <= item_in;
   end

endmodule
